@@ hdl/hcbd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbd_pkg - chunked body decoder shared definitions
// types, codes and byte helpers used by the step logic and the top level
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int LIMIT_BITS     = 32;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_DATA    = 3'd1,
    PH_TRAILER = 3'd2,
    PH_FINAL   = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_BAD   = 2'd1,
    ERR_LARGE = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ST_CONTINUE = 2'd0,
    ST_DONE     = 2'd1,
    ST_ERROR    = 2'd2
  } status_t;

  // parser control state
  typedef struct packed {
    phase_t     phase;
    logic       seen_cr;
    logic       have_digit;
    err_t       err_kind;
  } flags_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       payload_valid;
    logic       consumed;
    status_t    parse_status;
    err_t       error_code;
  } result_t;

  // hex digit decode: {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/hcbd_step.sv @@
// ----------------------------------------------------------------------------
// hcbd_step - per-byte parse logic
// next state and result for one raw byte of a chunked body
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_step #(
  parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
  input  wire logic [7:0]                      in_byte,
  input  wire logic [hcbd_pkg::LIMIT_BITS-1:0] max_body_size,
  input  wire hcbd_pkg::flags_t                flags,
  input  wire logic [COUNT_BITS-1:0]           size_accum,
  input  wire logic [COUNT_BITS-1:0]           chunk_left,
  input  wire logic [COUNT_BITS-1:0]           body_total,
  output hcbd_pkg::flags_t                     flags_next,
  output logic [COUNT_BITS-1:0]                size_accum_next,
  output logic [COUNT_BITS-1:0]                chunk_left_next,
  output logic [COUNT_BITS-1:0]                body_total_next,
  output hcbd_pkg::result_t                    result
);

  localparam int SUM_W = ((COUNT_BITS > hcbd_pkg::LIMIT_BITS) ?
                          COUNT_BITS : hcbd_pkg::LIMIT_BITS) + 1;

  logic [4:0]            hex;
  logic [COUNT_BITS-1:0] add_n;
  logic [SUM_W-1:0]      grown;
  logic                  over;
  logic [COUNT_BITS-1:0] chunk_dec;
  hcbd_pkg::err_t        fail;

  assign hex = hcbd_pkg::hex_decode(in_byte);

  // one limit adder, shared: one byte in data, the new chunk size on a size line
  assign add_n = (flags.phase == hcbd_pkg::PH_DATA) ? COUNT_BITS'(1) : size_accum;
  assign grown = SUM_W'(body_total) + SUM_W'(add_n);
  assign over  = (max_body_size != '0) && (grown > SUM_W'(max_body_size));

  assign chunk_dec = chunk_left - COUNT_BITS'(1);

  always_comb begin
    flags_next             = flags;
    size_accum_next        = size_accum;
    chunk_left_next        = chunk_left;
    body_total_next        = body_total;
    result.out_byte        = 8'd0;
    result.payload_valid   = 1'b0;
    result.consumed        = 1'b1;
    result.parse_status    = hcbd_pkg::ST_CONTINUE;
    fail                   = hcbd_pkg::ERR_NONE;

    case (flags.phase)
      hcbd_pkg::PH_SIZE: begin
        if (flags.seen_cr) begin
          if (in_byte != hcbd_pkg::CHAR_LF) begin
            fail = hcbd_pkg::ERR_BAD;
          end else if (size_accum == '0) begin
            flags_next.seen_cr = 1'b0;
            flags_next.phase   = hcbd_pkg::PH_FINAL;
          end else if (over) begin
            fail = hcbd_pkg::ERR_LARGE;
          end else begin
            flags_next.seen_cr = 1'b0;
            chunk_left_next    = size_accum;
            flags_next.phase   = hcbd_pkg::PH_DATA;
          end
        end else if (in_byte == hcbd_pkg::CHAR_CR) begin
          if (!flags.have_digit) begin
            fail = hcbd_pkg::ERR_BAD;
          end else begin
            flags_next.seen_cr = 1'b1;
          end
        end else begin
          // top nibble set means another digit would overflow
          if (!hex[4] || (size_accum[COUNT_BITS-1 -: 4] != 4'd0)) begin
            fail = hcbd_pkg::ERR_BAD;
          end else begin
            size_accum_next       = {size_accum[COUNT_BITS-5:0], hex[3:0]};
            flags_next.have_digit = 1'b1;
          end
        end
      end

      hcbd_pkg::PH_DATA: begin
        if (over) begin
          fail = hcbd_pkg::ERR_LARGE;
        end else begin
          result.out_byte      = in_byte;
          result.payload_valid = 1'b1;
          body_total_next      = body_total + COUNT_BITS'(1);
          chunk_left_next      = chunk_dec;
          if (chunk_dec == '0) begin
            flags_next.phase = hcbd_pkg::PH_TRAILER;
          end
        end
      end

      hcbd_pkg::PH_TRAILER, hcbd_pkg::PH_FINAL: begin
        if (flags.seen_cr) begin
          if (in_byte != hcbd_pkg::CHAR_LF) begin
            fail = hcbd_pkg::ERR_BAD;
          end else begin
            flags_next.seen_cr = 1'b0;
            if (flags.phase == hcbd_pkg::PH_TRAILER) begin
              flags_next.phase      = hcbd_pkg::PH_SIZE;
              flags_next.have_digit = 1'b0;
              size_accum_next       = '0;
            end else begin
              flags_next.phase    = hcbd_pkg::PH_DONE;
              result.parse_status = hcbd_pkg::ST_DONE;
            end
          end
        end else if (in_byte == hcbd_pkg::CHAR_CR) begin
          flags_next.seen_cr = 1'b1;
        end else begin
          fail = hcbd_pkg::ERR_BAD;
        end
      end

      default: begin
        // done or failed: nothing more is taken
        result.consumed     = 1'b0;
        result.parse_status = hcbd_pkg::ST_DONE;
      end
    endcase

    if (fail != hcbd_pkg::ERR_NONE) begin
      flags_next.err_kind  = fail;
      flags_next.phase     = hcbd_pkg::PH_DONE;
      result.out_byte      = 8'd0;
      result.payload_valid = 1'b0;
      result.consumed      = 1'b0;
      result.parse_status  = hcbd_pkg::ST_ERROR;
    end

    result.error_code = flags_next.err_kind;
  end

endmodule

`default_nettype wire

@@ hdl/http_chunked_body_decoder_core.sv @@
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core - chunked transfer body decoder
// takes the raw chunked body a byte at a time, gives one result per byte
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ----------------------------------
//  input     in         in_valid / in_stall    in_byte
//  output    out        out_valid / out_stall  out_byte, payload_valid, consumed,
//                                              parse_status, error_code
//  config    in         cfg_write              cfg_data (max_body_size)
//
//  one byte per cycle sustained while out_stall is low; each byte is held in the
//  input register, then the parse logic writes its result into the result register,
//  from which its result transaction is taken
//  the parse step is a single pass of compares, a shift-add and one limit adder
//  rst is synchronous: clears parser state, limit, and both valid flags
//  a held result does not block the input register from taking one byte;
//  in_stall rises only when both the input and result registers are full
//  a new message needs rst; the error and done conditions are sticky
//
`default_nettype none

module http_chunked_body_decoder_core #(
  parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             cfg_write,
  input  wire logic [hcbd_pkg::LIMIT_BITS-1:0]  cfg_data,
  // raw byte input
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       in_byte,
  // result output
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            out_byte,
  output logic                                  payload_valid,
  output logic                                  consumed,
  output logic [1:0]                            parse_status,
  output logic [1:0]                            error_code
);

  // limit register, zero means unlimited
  logic [hcbd_pkg::LIMIT_BITS-1:0] max_body_size;

  // input register
  logic       in_full;
  logic [7:0] in_hold;

  // parser state
  hcbd_pkg::flags_t      flags;
  logic [COUNT_BITS-1:0] size_accum;
  logic [COUNT_BITS-1:0] chunk_left;
  logic [COUNT_BITS-1:0] body_total;

  hcbd_pkg::flags_t      flags_next;
  logic [COUNT_BITS-1:0] size_accum_next;
  logic [COUNT_BITS-1:0] chunk_left_next;
  logic [COUNT_BITS-1:0] body_total_next;
  hcbd_pkg::result_t     step_result;

  // result register
  hcbd_pkg::result_t     res;

  logic advance;

  // held byte moves into the result register whenever that register is free
  // or being emptied this cycle
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && out_valid && out_stall;

  hcbd_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .in_byte         (in_hold),
    .max_body_size   (max_body_size),
    .flags           (flags),
    .size_accum      (size_accum),
    .chunk_left      (chunk_left),
    .body_total      (body_total),
    .flags_next      (flags_next),
    .size_accum_next (size_accum_next),
    .chunk_left_next (chunk_left_next),
    .body_total_next (body_total_next),
    .result          (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_size    <= '0;
      in_full          <= 1'b0;
      out_valid        <= 1'b0;
      flags.phase      <= hcbd_pkg::PH_SIZE;
      flags.seen_cr    <= 1'b0;
      flags.have_digit <= 1'b0;
      flags.err_kind   <= hcbd_pkg::ERR_NONE;
      size_accum       <= '0;
      chunk_left       <= '0;
      body_total       <= '0;
    end else begin
      if (cfg_write) begin
        max_body_size <= cfg_data;
      end

      // input register: load on a transaction, drain on advance
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      // parse step and result register
      if (advance) begin
        flags      <= flags_next;
        size_accum <= size_accum_next;
        chunk_left <= chunk_left_next;
        body_total <= body_total_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_hold <= in_byte;
    end
    if (advance) begin
      res <= step_result;
    end
  end

  assign out_byte      = res.out_byte;
  assign payload_valid = res.payload_valid;
  assign consumed      = res.consumed;
  assign parse_status  = res.parse_status;
  assign error_code    = res.error_code;

  // a sticky error never changes once set
  a_err_sticky : assert property (@(posedge clk) disable iff (rst)
    (flags.err_kind != hcbd_pkg::ERR_NONE) |=> (flags.err_kind == $past(flags.err_kind)))
    else $error("error kind changed after being set");

  // done is terminal until reset
  a_done_sticky : assert property (@(posedge clk) disable iff (rst)
    (flags.phase == hcbd_pkg::PH_DONE) |=> (flags.phase == hcbd_pkg::PH_DONE))
    else $error("parser left done phase without reset");

  // payload is always a consumed byte
  a_payload_consumed : assert property (@(posedge clk) disable iff (rst)
    (out_valid && payload_valid) |-> (consumed && (parse_status == hcbd_pkg::ST_CONTINUE)))
    else $error("payload byte not marked consumed");

  // an error result always carries an error code
  a_error_code : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (parse_status == hcbd_pkg::ST_ERROR)) |->
    (error_code != hcbd_pkg::ERR_NONE))
    else $error("error status without error code");

  // the data phase always has bytes left to pass
  a_chunk_left : assert property (@(posedge clk) disable iff (rst)
    (flags.phase == hcbd_pkg::PH_DATA) |-> (chunk_left != '0))
    else $error("data phase with empty chunk count");

endmodule

`default_nettype wire

@@ tb/tb_http_chunked_body_decoder_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder_core - chunked body decoder testbench
// drives one chunked message through the decoder: a few hand-built chunks,
// then random chunks in several idle and stall phases with different body
// limits, then one randomly chosen clean or broken ending and trailing
// bytes that must be ignored; every result is checked against a predictor
// ----------------------------------------------------------------------------

module tb_http_chunked_body_decoder_core;

  // ways the message can end; only one per run, since errors are sticky
  typedef enum int {
    END_CLEAN,
    END_EMPTY_LINE,
    END_NON_HEX,
    END_CR_NOT_LF,
    END_OVERFLOW,
    END_LIMIT_AT_LF,
    END_LIMIT_IN_DATA,
    END_BAD_DATA_TAIL,
    END_BAD_LAST_TAIL,
    END_COUNT
  } ending_t;

  // --------------------------------------------------------------------------
  // decoder predictor and store of expected result transactions
  // --------------------------------------------------------------------------
  class chunk_body_scoreboard;
    logic [31:0]       max_body;
    hcbd_pkg::phase_t  stage;
    logic              seen_cr;
    logic              have_digit;
    logic [31:0]       size_accum;
    logic [31:0]       chunk_left;
    logic [31:0]       body_total;
    hcbd_pkg::err_t    err_kind;
    hcbd_pkg::result_t pending[$];
    int                n_bad;

    function new();
      max_body   = '0;
      stage      = hcbd_pkg::PH_SIZE;
      seen_cr    = 1'b0;
      have_digit = 1'b0;
      size_accum = '0;
      chunk_left = '0;
      body_total = '0;
      err_kind   = hcbd_pkg::ERR_NONE;
      n_bad      = 0;
    endfunction

    function void set_limit(logic [31:0] v);
      max_body = v;
    endfunction

    function int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    // adding n bytes would pass a nonzero limit
    function bit over_limit(logic [31:0] n);
      if (max_body == '0) return 1'b0;
      if (body_total > max_body) return 1'b1;
      return n > (max_body - body_total);
    endfunction

    function void note_byte(logic [7:0] b);
      hcbd_pkg::result_t r;
      hcbd_pkg::err_t    fail;
      int                dig;
      r = '0;
      r.consumed     = 1'b1;
      r.parse_status = hcbd_pkg::ST_CONTINUE;
      fail = hcbd_pkg::ERR_NONE;
      dig  = hex_digit(b);
      case (stage)
        hcbd_pkg::PH_SIZE: begin
          if (seen_cr) begin
            if (b != hcbd_pkg::CHAR_LF) begin
              fail = hcbd_pkg::ERR_BAD;
            end else if (size_accum == '0) begin
              seen_cr = 1'b0;
              stage   = hcbd_pkg::PH_FINAL;
            end else if (over_limit(size_accum)) begin
              fail = hcbd_pkg::ERR_LARGE;
            end else begin
              seen_cr    = 1'b0;
              chunk_left = size_accum;
              stage      = hcbd_pkg::PH_DATA;
            end
          end else if (b == hcbd_pkg::CHAR_CR) begin
            if (!have_digit) fail = hcbd_pkg::ERR_BAD;
            else seen_cr = 1'b1;
          end else if (dig < 0 || size_accum > (32'hFFFF_FFFF - 32'(dig)) / 32'd16) begin
            fail = hcbd_pkg::ERR_BAD;
          end else begin
            size_accum = size_accum * 32'd16 + 32'(dig);
            have_digit = 1'b1;
          end
        end
        hcbd_pkg::PH_DATA: begin
          if (over_limit(32'd1)) begin
            fail = hcbd_pkg::ERR_LARGE;
          end else begin
            r.out_byte      = b;
            r.payload_valid = 1'b1;
            body_total      = body_total + 32'd1;
            chunk_left      = chunk_left - 32'd1;
            if (chunk_left == '0) stage = hcbd_pkg::PH_TRAILER;
          end
        end
        hcbd_pkg::PH_TRAILER, hcbd_pkg::PH_FINAL: begin
          if (seen_cr) begin
            if (b != hcbd_pkg::CHAR_LF) begin
              fail = hcbd_pkg::ERR_BAD;
            end else begin
              seen_cr = 1'b0;
              if (stage == hcbd_pkg::PH_TRAILER) begin
                stage      = hcbd_pkg::PH_SIZE;
                have_digit = 1'b0;
                size_accum = '0;
              end else begin
                stage          = hcbd_pkg::PH_DONE;
                r.parse_status = hcbd_pkg::ST_DONE;
              end
            end
          end else if (b == hcbd_pkg::CHAR_CR) begin
            seen_cr = 1'b1;
          end else begin
            fail = hcbd_pkg::ERR_BAD;
          end
        end
        default: begin
          r.consumed     = 1'b0;
          r.parse_status = hcbd_pkg::ST_DONE;
        end
      endcase
      if (fail != hcbd_pkg::ERR_NONE) begin
        err_kind        = fail;
        stage           = hcbd_pkg::PH_DONE;
        r.out_byte      = '0;
        r.payload_valid = 1'b0;
        r.consumed      = 1'b0;
        r.parse_status  = hcbd_pkg::ST_ERROR;
      end
      r.error_code = err_kind;
      pending.push_back(r);
    endfunction

    function void check_result(hcbd_pkg::result_t got);
      hcbd_pkg::result_t want;
      if (pending.size() == 0) begin
        if (n_bad < 10)
          $display("unexpected result transaction: byte %02h pv %0d cons %0d st %0d err %0d",
                   got.out_byte, got.payload_valid, got.consumed, got.parse_status,
                   got.error_code);
        n_bad++;
        return;
      end
      want = pending.pop_front();
      if (got.out_byte !== want.out_byte || got.payload_valid !== want.payload_valid ||
          got.consumed !== want.consumed || got.parse_status !== want.parse_status ||
          got.error_code !== want.error_code) begin
        if (n_bad < 10)
          $display("mismatch at %0t: expected byte %02h pv %0d cons %0d st %0d err %0d",
                   $realtime, want.out_byte, want.payload_valid, want.consumed,
                   want.parse_status, want.error_code);
        if (n_bad < 10)
          $display("                 got byte %02h pv %0d cons %0d st %0d err %0d",
                   got.out_byte, got.payload_valid, got.consumed, got.parse_status,
                   got.error_code);
        n_bad++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block connections
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_write = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_byte   = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        payload_valid;
  logic        consumed;
  logic [1:0]  parse_status;
  logic [1:0]  error_code;

  chunk_body_scoreboard sb;
  int snd_idle  = 0;   // percent of cycles the sender holds back
  int rcv_stall = 0;   // percent of cycles the receiver stalls
  int n_sent    = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  http_chunked_body_decoder_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .payload_valid (payload_valid),
    .consumed      (consumed),
    .parse_status  (parse_status),
    .error_code    (error_code)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_stall);
  end

  // monitor: values seen here are the ones from just before the edge, so a
  // transaction is noted exactly at the edge that moves it; results are
  // checked first, though they always belong to earlier input transactions
  always @(posedge clk) begin
    hcbd_pkg::result_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.out_byte      = out_byte;
        got.payload_valid = payload_valid;
        got.consumed      = consumed;
        got.parse_status  = hcbd_pkg::status_t'(parse_status);
        got.error_code    = hcbd_pkg::err_t'(error_code);
        sb.check_result(got);
      end
      if (in_valid && !in_stall) sb.note_byte(in_byte);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // one input transaction, with random sender gaps before it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(hcbd_pkg::CHAR_CR);
    send_byte(hcbd_pkg::CHAR_LF);
  endtask

  // hex size with random letter case and, now and then, leading zeros
  function automatic string size_text(input int unsigned n);
    string       hx;
    string       t;
    int          zeros;
    logic [7:0]  c;
    hx    = $sformatf("%0h", n);
    zeros = ($urandom_range(7) == 0) ? $urandom_range(1, 8) : 0;
    t     = "";
    repeat (zeros) t = {t, "0"};
    for (int i = 0; i < hx.len(); i++) begin
      c = hx[i];
      if (c >= "a" && $urandom_range(1) == 1) c = c - 8'd32;
      t = {t, $sformatf("%c", c)};
    end
    return t;
  endfunction

  task automatic send_chunk(input int unsigned n);
    send_text(size_text(n));
    send_crlf();
    repeat (n) send_byte(8'($urandom));
    send_crlf();
  endtask

  function automatic logic [7:0] other_than(input logic [7:0] avoid);
    logic [7:0] c;
    do c = 8'($urandom); while (c == avoid);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    do c = 8'($urandom); while (sb.hex_digit(c) >= 0 || c == hcbd_pkg::CHAR_CR);
    return c;
  endfunction

  // drop valid and wait until every expected result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_limit(v);
  endtask

  task automatic set_mode(input int m);
    case (m)
      0: begin snd_idle = 0;  rcv_stall = 0;  end
      1: begin snd_idle = 83; rcv_stall = 0;  end
      2: begin snd_idle = 0;  rcv_stall = 83; end
      default: begin snd_idle = 28; rcv_stall = 28; end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    ending_t     ending;
    int unsigned n;
    int unsigned m;
    logic [31:0] acc;
    sb = new();
    set_mode(0);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_limit(32'd0);

    // hand-built chunks: payload extremes, CR and LF inside data, leading zeros
    send_text("1");
    send_crlf();
    send_byte(8'h00);
    send_crlf();
    send_text("0003");
    send_crlf();
    send_byte(8'hff);
    send_byte(hcbd_pkg::CHAR_CR);
    send_byte(hcbd_pkg::CHAR_LF);
    send_crlf();

    // random chunks, one idle pattern and one body limit per phase
    for (int ph = 0; ph < 8; ph++) begin
      set_mode(ph % 4);
      if (ph > 0) begin
        wait_idle();
        case (ph % 4)
          1: write_limit(32'hFFFF_FFFF);
          2: write_limit(32'd0);
          3: write_limit(sb.body_total + 32'd1024 + 32'($urandom_range(1000)));
          default: write_limit(32'h8000_0000);
        endcase
      end
      while (n_sent < 14 + (ph + 1) * 85) begin
        if ($urandom_range(9) == 0) send_chunk($urandom_range(25, 64));
        else send_chunk($urandom_range(1, 24));
      end
    end

    // the one ending of this message
    set_mode($urandom_range(3));
    ending = ending_t'($urandom_range(END_COUNT - 1));
    case (ending)
      END_CLEAN: begin
        send_text(size_text(0));
        send_crlf();
        send_crlf();
      end
      END_EMPTY_LINE: begin
        send_byte(hcbd_pkg::CHAR_CR);
      end
      END_NON_HEX: begin
        send_text(size_text($urandom_range(1, 40)));
        case ($urandom_range(3))
          0: send_byte(";");
          1: send_byte(" ");
          2: send_byte(hcbd_pkg::CHAR_LF);
          default: send_byte(non_hex_byte());
        endcase
      end
      END_CR_NOT_LF: begin
        send_text(size_text($urandom_range(1, 40)));
        send_byte(hcbd_pkg::CHAR_CR);
        send_byte(other_than(hcbd_pkg::CHAR_LF));
      end
      END_OVERFLOW: begin
        // eight digits at or above 0x10000000 leave no room for a ninth
        acc = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h1000_0000);
        send_text($sformatf("%08h", acc));
        send_byte(($urandom_range(1) == 1) ? "F" : "0");
      end
      END_LIMIT_AT_LF: begin
        wait_idle();
        n = $urandom_range(1, 8);
        write_limit(sb.body_total + 32'(n));
        if ($urandom_range(1) == 1) begin
          send_chunk(n);   // exact fit still passes
          send_text(size_text($urandom_range(1, 5)));
        end else begin
          send_text("ffffffff");
        end
        send_crlf();
      end
      END_LIMIT_IN_DATA: begin
        // limit lowered to the current total in the middle of a chunk
        n = $urandom_range(2, 20);
        m = $urandom_range(1, n - 1);
        send_text(size_text(n));
        send_crlf();
        repeat (m) send_byte(8'($urandom));
        wait_idle();
        write_limit(sb.body_total);
        repeat (n - m) send_byte(8'($urandom));
      end
      END_BAD_DATA_TAIL: begin
        n = $urandom_range(1, 20);
        send_text(size_text(n));
        send_crlf();
        repeat (n) send_byte(8'($urandom));
        if ($urandom_range(1) == 1) begin
          send_byte(other_than(hcbd_pkg::CHAR_CR));
        end else begin
          send_byte(hcbd_pkg::CHAR_CR);
          send_byte(other_than(hcbd_pkg::CHAR_LF));
        end
      end
      default: begin
        send_text(size_text(0));
        send_crlf();
        if ($urandom_range(1) == 1) begin
          send_byte(other_than(hcbd_pkg::CHAR_CR));
        end else begin
          send_byte(hcbd_pkg::CHAR_CR);
          send_byte(other_than(hcbd_pkg::CHAR_LF));
        end
      end
    endcase

    // anything after done or an error must be refused
    repeat (16) send_byte(8'($urandom));

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.n_bad == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
